// ----- rtl/sccp_pkg.sv -----
// Shared types and constants of the second-chance page fault unit.
`default_nettype none

package sccp_pkg;

   // Fixed widths of the request and response word fields.
   localparam int VA_W        = 14;
   localparam int PROC_IN_W   = 4;
   localparam int STATUS_W    = 3;
   localparam int FRAME_OUT_W = 5;
   localparam int EVPROC_W    = 4;
   localparam int EVPAGE_W    = 6;

   // Operation code that requests a page-table frame.
   localparam logic OP_ALLOC = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      RSP_HIT   = 3'd0,
      RSP_FREE  = 3'd1,
      RSP_EVICT = 3'd2,
      RSP_TABLE = 3'd3,
      RSP_NONE  = 3'd4
   } rsp_status_type;

   typedef struct packed {
      logic                 operation;
      logic [PROC_IN_W-1:0] process;
      logic [VA_W-1:0]      vaddr;
      logic                 is_write;
   } req_word_type;

   typedef struct packed {
      rsp_status_type         status;
      logic [FRAME_OUT_W-1:0] frame;
      logic [EVPROC_W-1:0]    evicted_process;
      logic [EVPAGE_W-1:0]    evicted_page;
      logic                   evicted_dirty;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV1,
      S_DIV2,
      S_DIV3,
      S_ADDR,
      S_LOOKUP,
      S_LOOKUP_CHECK,
      S_HIT_READ,
      S_HIT_WRITE,
      S_TAKE,
      S_SWEEP_READ,
      S_SWEEP_CHECK,
      S_EVICT_READ,
      S_EVICT_CHECK,
      S_INSTALL,
      S_CLEAR_PROC,
      S_FINISH
   } state_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [4:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_DIV1,
      DP_DIV2,
      DP_DIV3,
      DP_ADDR,
      DP_LOOKUP,
      DP_HIT_READ,
      DP_HIT_WRITE,
      DP_TAKE,
      DP_SWEEP_READ,
      DP_SWEEP_CHECK,
      DP_EVICT_READ,
      DP_EVICT_CHECK,
      DP_INSTALL,
      DP_CLEAR_PROC,
      DP_RESET_CLEAR,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alloc;
      logic hit;
      logic has_free;
      logic all_tables;
      logic skip;
      logic rst_clear_done;
      logic proc_clear_done;
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/sccp_ctrl.sv -----
// Controller state machine of the second-chance page fault unit.
`default_nettype none

module sccp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sccp_pkg::dp_stat_type  stat,
   output sccp_pkg::ctrl_cmd_type      cmd
);

   sccp_pkg::state_type state_ff;
   sccp_pkg::state_type state_in;

   // State register; reset starts the page-table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sccp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sccp_pkg::S_CLEAR: begin
            if (stat.rst_clear_done) state_in = sccp_pkg::S_IDLE;
         end
         sccp_pkg::S_IDLE: begin
            if (req_valid) state_in = sccp_pkg::S_DIV1;
         end
         sccp_pkg::S_DIV1: state_in = sccp_pkg::S_DIV2;
         sccp_pkg::S_DIV2: state_in = sccp_pkg::S_DIV3;
         sccp_pkg::S_DIV3: state_in = sccp_pkg::S_ADDR;
         sccp_pkg::S_ADDR: begin
            state_in = stat.alloc ? sccp_pkg::S_TAKE : sccp_pkg::S_LOOKUP;
         end
         sccp_pkg::S_LOOKUP: state_in = sccp_pkg::S_LOOKUP_CHECK;
         sccp_pkg::S_LOOKUP_CHECK: begin
            state_in = stat.hit ? sccp_pkg::S_HIT_READ : sccp_pkg::S_TAKE;
         end
         sccp_pkg::S_HIT_READ: state_in = sccp_pkg::S_HIT_WRITE;
         sccp_pkg::S_HIT_WRITE: state_in = sccp_pkg::S_FINISH;
         sccp_pkg::S_TAKE: begin
            if (stat.has_free) begin
               state_in = sccp_pkg::S_INSTALL;
            end else if (stat.all_tables) begin
               state_in = sccp_pkg::S_FINISH;
            end else begin
               state_in = sccp_pkg::S_SWEEP_READ;
            end
         end
         sccp_pkg::S_SWEEP_READ: state_in = sccp_pkg::S_SWEEP_CHECK;
         sccp_pkg::S_SWEEP_CHECK: begin
            state_in = stat.skip ? sccp_pkg::S_SWEEP_READ : sccp_pkg::S_EVICT_READ;
         end
         sccp_pkg::S_EVICT_READ: state_in = sccp_pkg::S_EVICT_CHECK;
         sccp_pkg::S_EVICT_CHECK: state_in = sccp_pkg::S_INSTALL;
         sccp_pkg::S_INSTALL: begin
            state_in = stat.alloc ? sccp_pkg::S_CLEAR_PROC : sccp_pkg::S_FINISH;
         end
         sccp_pkg::S_CLEAR_PROC: begin
            if (stat.proc_clear_done) state_in = sccp_pkg::S_FINISH;
         end
         sccp_pkg::S_FINISH: begin
            if (stat.rsp_free) state_in = sccp_pkg::S_IDLE;
         end
         default: state_in = sccp_pkg::S_IDLE;
      endcase
   end

   // Outputs: request ready and the datapath operation of this cycle.
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = sccp_pkg::DP_NOP;
      case (state_ff)
         sccp_pkg::S_CLEAR:        cmd.op = sccp_pkg::DP_RESET_CLEAR;
         sccp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = sccp_pkg::DP_CAPTURE;
         end
         sccp_pkg::S_DIV1:         cmd.op = sccp_pkg::DP_DIV1;
         sccp_pkg::S_DIV2:         cmd.op = sccp_pkg::DP_DIV2;
         sccp_pkg::S_DIV3:         cmd.op = sccp_pkg::DP_DIV3;
         sccp_pkg::S_ADDR:         cmd.op = sccp_pkg::DP_ADDR;
         sccp_pkg::S_LOOKUP:       cmd.op = sccp_pkg::DP_LOOKUP;
         sccp_pkg::S_LOOKUP_CHECK: cmd.op = sccp_pkg::DP_NOP;
         sccp_pkg::S_HIT_READ:     cmd.op = sccp_pkg::DP_HIT_READ;
         sccp_pkg::S_HIT_WRITE:    cmd.op = sccp_pkg::DP_HIT_WRITE;
         sccp_pkg::S_TAKE:         cmd.op = sccp_pkg::DP_TAKE;
         sccp_pkg::S_SWEEP_READ:   cmd.op = sccp_pkg::DP_SWEEP_READ;
         sccp_pkg::S_SWEEP_CHECK:  cmd.op = sccp_pkg::DP_SWEEP_CHECK;
         sccp_pkg::S_EVICT_READ:   cmd.op = sccp_pkg::DP_EVICT_READ;
         sccp_pkg::S_EVICT_CHECK:  cmd.op = sccp_pkg::DP_EVICT_CHECK;
         sccp_pkg::S_INSTALL:      cmd.op = sccp_pkg::DP_INSTALL;
         sccp_pkg::S_CLEAR_PROC:   cmd.op = sccp_pkg::DP_CLEAR_PROC;
         sccp_pkg::S_FINISH: begin
            if (stat.rsp_free) cmd.op = sccp_pkg::DP_FINISH;
         end
         default: cmd.op = sccp_pkg::DP_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/sccp_dp.sv -----
// Datapath of the second-chance page fault unit: tables, clock hand, result word.
`default_nettype none

module sccp_dp #(
   parameter int FRAMES            = 32,
   parameter int PROCESSES         = 16,
   parameter int PAGES_PER_PROCESS = 64,
   parameter int PAGE_BYTES        = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sccp_pkg::req_word_type req_word,
   input  wire sccp_pkg::ctrl_cmd_type cmd,
   output sccp_pkg::dp_stat_type       stat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output sccp_pkg::rsp_word_type      rsp_word
);

   localparam int FRAME_W  = $clog2(FRAMES);
   localparam int FILL_W   = $clog2(FRAMES + 1);
   localparam int PROC_W   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int PAGE_W   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
   localparam int PT_DEPTH = PROCESSES * PAGES_PER_PROCESS;
   localparam int PT_AW    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
   localparam int PTP_W    = PT_AW + 1;

   localparam int AW_VA    = sccp_pkg::VA_W;
   localparam int AW_PIN   = sccp_pkg::PROC_IN_W;
   localparam int OUT_FR_W = sccp_pkg::FRAME_OUT_W;
   localparam int OUT_EP_W = sccp_pkg::EVPROC_W;
   localparam int OUT_PG_W = sccp_pkg::EVPAGE_W;

   // Reciprocals for exact division of the address by the page size, of the page number
   // by the table size and of the process by PROCESSES (ceil of 2^(N+l) / d).
   localparam int RCP_W   = AW_VA + 1;
   localparam int PROD_W  = AW_VA + RCP_W;
   localparam int SH_PG   = AW_VA + $clog2(PAGE_BYTES);
   localparam longint unsigned RCP_PG =
      ((64'd1 << SH_PG) + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int SH_PP   = AW_VA + $clog2(PAGES_PER_PROCESS);
   localparam longint unsigned RCP_PP =
      ((64'd1 << SH_PP) + PAGES_PER_PROCESS - 1) / PAGES_PER_PROCESS;
   localparam int RCPP_W  = AW_PIN + 1;
   localparam int PRODP_W = AW_PIN + RCPP_W;
   localparam int SH_PR   = AW_PIN + $clog2(PROCESSES);
   localparam longint unsigned RCP_PR =
      ((64'd1 << SH_PR) + PROCESSES - 1) / PROCESSES;

   typedef struct packed {
      logic              is_table;
      logic              referenced;
      logic              modified;
      logic [PROC_W-1:0] owner;
      logic [PAGE_W-1:0] vpage;
   } frame_rec_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } pt_entry_type;

   // Control registers.
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  table_cnt_ff, table_cnt_in;
   logic [FRAME_W-1:0] hand_ff, hand_in;
   logic [PT_AW-1:0]   rclr_ff, rclr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic               alloc_ff, alloc_in;
   logic               wr_ff, wr_in;
   logic [AW_VA-1:0]   va_ff, va_in;
   logic [AW_PIN-1:0]  pin_ff, pin_in;
   logic [AW_VA-1:0]   q1_ff, q1_in;
   logic [AW_VA-1:0]   q2_ff, q2_in;
   logic [AW_PIN-1:0]  pq_ff, pq_in;
   logic [PROC_W-1:0]  proc_ff, proc_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [PT_AW-1:0]   base_ff, base_in;
   logic [PT_AW-1:0]   req_addr_ff, req_addr_in;
   logic [PT_AW-1:0]   vic_addr_ff, vic_addr_in;
   logic [FRAME_W-1:0] fr_ff, fr_in;
   logic               evicted_ff, evicted_in;
   logic [PAGE_W-1:0]  pclr_ff, pclr_in;
   sccp_pkg::rsp_status_type res_status_ff, res_status_in;
   logic [OUT_FR_W-1:0] res_frame_ff, res_frame_in;
   logic [OUT_EP_W-1:0] res_evp_ff, res_evp_in;
   logic [OUT_PG_W-1:0] res_evpage_ff, res_evpage_in;
   logic               res_evd_ff, res_evd_in;
   sccp_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Memory ports.
   pt_entry_type       pt_mem [PT_DEPTH];
   pt_entry_type       pt_q_ff;
   logic               pt_we, pt_re;
   logic [PT_AW-1:0]   pt_wa, pt_ra;
   pt_entry_type       pt_wd;
   frame_rec_type      fr_mem [FRAMES];
   frame_rec_type      fq_ff;
   logic               fr_we, fr_re;
   logic [FRAME_W-1:0] fr_wa, fr_ra;
   frame_rec_type      fr_wd;

   // Arithmetic helpers.
   logic [PROD_W-1:0]  pg_prod;
   logic [PROD_W-1:0]  pp_prod;
   logic [PRODP_W-1:0] pr_prod;
   logic [PRODP_W-1:0] pr_back;
   logic [AW_VA-1:0]   pp_back;
   logic [PT_AW-1:0]   base_mul;
   logic [PT_AW-1:0]   vic_base;
   logic [FRAME_W-1:0] hand_next;

   assign pg_prod  = PROD_W'(va_ff) * PROD_W'(RCP_PG);
   assign pp_prod  = PROD_W'(q1_ff) * PROD_W'(RCP_PP);
   assign pr_prod  = PRODP_W'(pin_ff) * PRODP_W'(RCP_PR);
   assign pr_back  = PRODP_W'(pq_ff) * PRODP_W'(PROCESSES);
   assign pp_back  = AW_VA'(q2_ff * AW_VA'(PAGES_PER_PROCESS));
   assign base_mul = PT_AW'(PTP_W'(proc_ff) * PTP_W'(PAGES_PER_PROCESS));
   assign vic_base = PT_AW'(PTP_W'(fq_ff.owner) * PTP_W'(PAGES_PER_PROCESS));
   assign hand_next = (hand_ff == FRAME_W'(FRAMES - 1)) ? '0 : hand_ff + FRAME_W'(1);

   // Status back to the controller.
   always_comb begin
      stat.alloc           = alloc_ff;
      stat.hit             = pt_q_ff.valid && (FILL_W'(pt_q_ff.frame) < FILL_W'(FRAMES));
      stat.has_free        = fill_ff < FILL_W'(FRAMES);
      stat.all_tables      = table_cnt_ff == FILL_W'(FRAMES);
      stat.skip            = fq_ff.is_table || fq_ff.referenced;
      stat.rst_clear_done  = rclr_ff == PT_AW'(PT_DEPTH - 1);
      stat.proc_clear_done = pclr_ff == PAGE_W'(PAGES_PER_PROCESS - 1);
      stat.rsp_free        = !rsp_valid_ff || rsp_ready;
   end

   // Next values of all registers and the memory port controls.
   always_comb begin
      fill_in       = fill_ff;
      table_cnt_in  = table_cnt_ff;
      hand_in       = hand_ff;
      rclr_in       = rclr_ff;
      rsp_valid_in  = rsp_valid_ff;
      alloc_in      = alloc_ff;
      wr_in         = wr_ff;
      va_in         = va_ff;
      pin_in        = pin_ff;
      q1_in         = q1_ff;
      q2_in         = q2_ff;
      pq_in         = pq_ff;
      proc_in       = proc_ff;
      page_in       = page_ff;
      base_in       = base_ff;
      req_addr_in   = req_addr_ff;
      vic_addr_in   = vic_addr_ff;
      fr_in         = fr_ff;
      evicted_in    = evicted_ff;
      pclr_in       = pclr_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_evp_in    = res_evp_ff;
      res_evpage_in = res_evpage_ff;
      res_evd_in    = res_evd_ff;
      rsp_word_in   = rsp_word_ff;
      pt_we = 1'b0;
      pt_re = 1'b0;
      pt_wa = req_addr_ff;
      pt_ra = req_addr_ff;
      pt_wd = '0;
      fr_we = 1'b0;
      fr_re = 1'b0;
      fr_wa = fr_ff;
      fr_ra = hand_ff;
      fr_wd = fq_ff;

      // The waiting response word leaves when it is taken.
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (cmd.op)
         sccp_pkg::DP_CAPTURE: begin
            alloc_in      = req_word.operation == sccp_pkg::OP_ALLOC;
            wr_in         = req_word.is_write;
            va_in         = req_word.vaddr;
            pin_in        = req_word.process;
            evicted_in    = 1'b0;
            res_status_in = sccp_pkg::RSP_HIT;
            res_frame_in  = '0;
            res_evp_in    = '0;
            res_evpage_in = '0;
            res_evd_in    = 1'b0;
         end
         sccp_pkg::DP_DIV1: begin
            q1_in = AW_VA'(pg_prod >> SH_PG);
            pq_in = AW_PIN'(pr_prod >> SH_PR);
         end
         sccp_pkg::DP_DIV2: begin
            q2_in   = AW_VA'(pp_prod >> SH_PP);
            proc_in = PROC_W'(PRODP_W'(pin_ff) - pr_back);
         end
         sccp_pkg::DP_DIV3: begin
            page_in = PAGE_W'(q1_ff - pp_back);
            base_in = base_mul;
         end
         sccp_pkg::DP_ADDR: begin
            req_addr_in = base_ff + PT_AW'(page_ff);
         end
         sccp_pkg::DP_LOOKUP: begin
            pt_re = 1'b1;
            pt_ra = req_addr_ff;
         end
         sccp_pkg::DP_HIT_READ: begin
            fr_re = 1'b1;
            fr_ra = pt_q_ff.frame;
            fr_in = pt_q_ff.frame;
         end
         sccp_pkg::DP_HIT_WRITE: begin
            fr_we            = 1'b1;
            fr_wa            = fr_ff;
            fr_wd            = fq_ff;
            fr_wd.referenced = 1'b1;
            fr_wd.modified   = fq_ff.modified | wr_ff;
            res_status_in    = sccp_pkg::RSP_HIT;
            res_frame_in     = OUT_FR_W'(fr_ff);
         end
         sccp_pkg::DP_TAKE: begin
            // Frames are never freed, so the lowest free frame is the fill count.
            if (stat.has_free) begin
               fr_in   = FRAME_W'(fill_ff);
               fill_in = fill_ff + FILL_W'(1);
            end else if (stat.all_tables) begin
               res_status_in = sccp_pkg::RSP_NONE;
            end
         end
         sccp_pkg::DP_SWEEP_READ: begin
            fr_re = 1'b1;
            fr_ra = hand_ff;
         end
         sccp_pkg::DP_SWEEP_CHECK: begin
            hand_in = hand_next;
            if (stat.skip) begin
               // Second chance: clear the reference bit and move on.
               fr_we            = 1'b1;
               fr_wa            = hand_ff;
               fr_wd            = fq_ff;
               fr_wd.referenced = 1'b0;
            end else begin
               fr_in         = hand_ff;
               evicted_in    = 1'b1;
               res_evp_in    = OUT_EP_W'(fq_ff.owner);
               res_evpage_in = OUT_PG_W'(fq_ff.vpage);
               res_evd_in    = fq_ff.modified;
               vic_addr_in   = vic_base + PT_AW'(fq_ff.vpage);
            end
         end
         sccp_pkg::DP_EVICT_READ: begin
            pt_re = 1'b1;
            pt_ra = vic_addr_ff;
         end
         sccp_pkg::DP_EVICT_CHECK: begin
            // Invalidate the owner's entry only if it still maps the victim.
            if (pt_q_ff.valid && (pt_q_ff.frame == fr_ff)) begin
               pt_we = 1'b1;
               pt_wa = vic_addr_ff;
               pt_wd = '0;
            end
         end
         sccp_pkg::DP_INSTALL: begin
            fr_we        = 1'b1;
            fr_wa        = fr_ff;
            res_frame_in = OUT_FR_W'(fr_ff);
            pclr_in      = '0;
            fr_wd.referenced = 1'b1;
            fr_wd.owner      = proc_ff;
            if (alloc_ff) begin
               fr_wd.is_table = 1'b1;
               fr_wd.modified = 1'b0;
               fr_wd.vpage    = '0;
               table_cnt_in   = table_cnt_ff + FILL_W'(1);
               res_status_in  = sccp_pkg::RSP_TABLE;
            end else begin
               fr_wd.is_table = 1'b0;
               fr_wd.modified = wr_ff;
               fr_wd.vpage    = page_ff;
               pt_we          = 1'b1;
               pt_wa          = req_addr_ff;
               pt_wd.valid    = 1'b1;
               pt_wd.frame    = fr_ff;
               res_status_in  = evicted_ff ? sccp_pkg::RSP_EVICT : sccp_pkg::RSP_FREE;
            end
         end
         sccp_pkg::DP_CLEAR_PROC: begin
            pt_we   = 1'b1;
            pt_wa   = base_ff + PT_AW'(pclr_ff);
            pt_wd   = '0;
            pclr_in = pclr_ff + PAGE_W'(1);
         end
         sccp_pkg::DP_RESET_CLEAR: begin
            pt_we   = 1'b1;
            pt_wa   = rclr_ff;
            pt_wd   = '0;
            rclr_in = rclr_ff + PT_AW'(1);
         end
         sccp_pkg::DP_FINISH: begin
            rsp_word_in.status          = res_status_ff;
            rsp_word_in.frame           = res_frame_ff;
            rsp_word_in.evicted_process = res_evp_ff;
            rsp_word_in.evicted_page    = res_evpage_ff;
            rsp_word_in.evicted_dirty   = res_evd_ff;
            rsp_valid_in                = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Page table memory, registered read.
   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_wa] <= pt_wd;
      if (pt_re) pt_q_ff <= pt_mem[pt_ra];
   end

   // Frame table memory, registered read.
   always_ff @(posedge clock) begin
      if (fr_we) fr_mem[fr_wa] <= fr_wd;
      if (fr_re) fq_ff <= fr_mem[fr_ra];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         table_cnt_ff <= '0;
         hand_ff      <= '0;
         rclr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         table_cnt_ff <= table_cnt_in;
         hand_ff      <= hand_in;
         rclr_ff      <= rclr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      alloc_ff      <= alloc_in;
      wr_ff         <= wr_in;
      va_ff         <= va_in;
      pin_ff        <= pin_in;
      q1_ff         <= q1_in;
      q2_ff         <= q2_in;
      pq_ff         <= pq_in;
      proc_ff       <= proc_in;
      page_ff       <= page_in;
      base_ff       <= base_in;
      req_addr_ff   <= req_addr_in;
      vic_addr_ff   <= vic_addr_in;
      fr_ff         <= fr_in;
      evicted_ff    <= evicted_in;
      pclr_ff       <= pclr_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_evp_ff    <= res_evp_in;
      res_evpage_ff <= res_evpage_in;
      res_evd_ff    <= res_evd_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/second_chance_page_fault_unit.sv -----
// Top level of the second-chance page fault unit.
//
//   Channel   Direction  Handshake              Word
//   req       in         req_valid/req_ready    sccp_pkg::req_word_type
//   rsp       out        rsp_valid/rsp_ready    sccp_pkg::rsp_word_type
//
// A hit passes address arithmetic (DIV1, DIV2, DIV3, ADDR), table lookup (LOOKUP,
// LOOKUP_CHECK), frame work (HIT_READ, HIT_WRITE) and result load (FINISH); a miss
// with a free frame does TAKE and INSTALL instead. The next word can be taken in the
// cycle after the result load. An eviction adds a sweep read and check per frame the
// clock hand visits (up to 2*FRAMES+1 visits) and a read and check to drop the owner's
// entry. An allocate skips the lookup and clears its process's entries. After reset
// no word is taken while the page table is cleared. A result waits in the output
// register while the next word is accepted; the last step stalls while it stays full.
`default_nettype none

module second_chance_page_fault_unit #(
   parameter int FRAMES            = 32,
   parameter int PROCESSES         = 16,
   parameter int PAGES_PER_PROCESS = 64,
   parameter int PAGE_BYTES        = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sccp_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output sccp_pkg::rsp_word_type      rsp_word
);

   sccp_pkg::ctrl_cmd_type dp_cmd;
   sccp_pkg::dp_stat_type  dp_stat;

   // Sequencer.
   sccp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // Tables, clock hand and response register.
   sccp_dp #(
      .FRAMES            (FRAMES),
      .PROCESSES         (PROCESSES),
      .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
      .PAGE_BYTES        (PAGE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTH
   // One request word at a time: the unit is busy right after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request was in flight");

   // A failed request reports no frame and no eviction.
   a_none_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == sccp_pkg::RSP_NONE) |->
         (rsp_word.frame == '0) && (rsp_word.evicted_process == '0) &&
         (rsp_word.evicted_page == '0) && !rsp_word.evicted_dirty)
      else $error("no-frame response carries frame or eviction data");

   // Hits and free-frame faults evict nothing.
   a_no_evict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_word.status == sccp_pkg::RSP_HIT) ||
                    (rsp_word.status == sccp_pkg::RSP_FREE)) |->
         (rsp_word.evicted_process == '0) && (rsp_word.evicted_page == '0) &&
         !rsp_word.evicted_dirty)
      else $error("eviction data on a response without eviction");

   // Table frames are always counted among the filled frames.
   a_free_vs_tables: assert property (@(posedge clock) disable iff (reset)
      !(dp_stat.has_free && dp_stat.all_tables))
      else $error("free frame seen while every frame holds a page table");
`endif

endmodule

`default_nettype wire
